// ===== hdl/blsl_pkg.sv =====
// shared types and constants for the bounded symbol list
package blsl_pkg;

	localparam int SYM_W = 6;
	localparam int IDX_W = 6;
	localparam int OUT_W = 7;
	localparam int LEN_W = 6;
	// wide enough for any cell position or count up to the largest capacity
	localparam int POS_W = 9;

	typedef enum logic [2:0] {
		ACT_INSERT   = 3'd0,
		ACT_REMOVE   = 3'd1,
		ACT_SET      = 3'd2,
		ACT_PUSH     = 3'd3,
		ACT_POP      = 3'd4,
		ACT_CLEAR    = 3'd5,
		ACT_GET      = 3'd6,
		ACT_CONTAINS = 3'd7
	} act_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT_UP,
		CELL_SHIFT_DOWN,
		CELL_WRITE
	} cell_mode_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		cell_mode_t             mode;
		logic [POS_W-1:0]       pos;
		logic [SYM_W-1:0]       sym;
		logic [POS_W-1:0]       cnt;
		logic [POS_W-1:0]       top_pos;
	} cell_cmd_t;

	// what one cell hands back for the reductions
	typedef struct packed {
		logic [SYM_W-1:0] rd;
		logic             fnd;
		logic [SYM_W-1:0] tp;
	} cell_rsp_t;

endpackage

// ===== hdl/bounded_symbol_list_unit.sv =====
// bounded symbol list: row of entry cells driven by a broadcast controller
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | in_valid, in_ready, action, index, value  | in
//  result  | out_valid, out_ready, read_value, found,  | out
//          | top_value, length, accepted               |
//
// on every operation all cells shift, write or compare in parallel, and
// the result register is loaded at the accepting edge.
// a new request is taken whenever the result register is empty or drains
// in the same cycle. reset empties the list and the result register;
// entry contents are not cleared.
module bounded_symbol_list_unit #(
	parameter int CAPACITY = 32,
	parameter int SYMBOLS  = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [2:0]                   action,
	input  logic [blsl_pkg::IDX_W-1:0]   index,
	input  logic [blsl_pkg::SYM_W-1:0]   value,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [blsl_pkg::OUT_W-1:0]   read_value,
	output logic                         found,
	output logic [blsl_pkg::OUT_W-1:0]   top_value,
	output logic [blsl_pkg::LEN_W-1:0]   length,
	output logic                         accepted
);
	import blsl_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [POS_W-1:0] CAP_P = POS_W'(CAPACITY);
	localparam logic [OUT_W-1:0] SENTINEL = OUT_W'(SYMBOLS);

	logic [CW-1:0]    count_q;
	logic             out_valid_q;
	logic [OUT_W-1:0] read_value_q;
	logic             found_q;
	logic [OUT_W-1:0] top_value_q;
	logic [LEN_W-1:0] length_q;
	logic             accepted_q;

	logic             in_fire;
	act_t             act;
	logic [POS_W-1:0] idx_p;
	logic [POS_W-1:0] cnt_p;
	logic [POS_W-1:0] next_cnt;
	logic             acc;
	cell_cmd_t        cmd;

	logic [SYM_W-1:0] cell_q [CAPACITY];
	cell_rsp_t        rsp [CAPACITY];

	logic [SYM_W-1:0] rd_or;
	logic [SYM_W-1:0] tp_or;
	logic             fnd_or;

	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign act      = act_t'(action);
	assign idx_p    = POS_W'(index);
	assign cnt_p    = POS_W'(count_q);

	always_comb begin
		acc      = 1'b0;
		next_cnt = cnt_p;
		cmd.mode = CELL_HOLD;
		cmd.pos  = idx_p;
		cmd.sym  = value;
		cmd.cnt  = cnt_p;
		unique case (act)
			ACT_INSERT: begin
				acc = (cnt_p < CAP_P) && (idx_p <= cnt_p);
				if (acc) begin
					cmd.mode = CELL_SHIFT_UP;
					next_cnt = cnt_p + 1'b1;
				end
			end
			ACT_REMOVE: begin
				acc = idx_p < cnt_p;
				if (acc) begin
					cmd.mode = CELL_SHIFT_DOWN;
					next_cnt = cnt_p - 1'b1;
				end
			end
			ACT_SET: begin
				acc = idx_p < cnt_p;
				if (acc)
					cmd.mode = CELL_WRITE;
			end
			ACT_PUSH: begin
				acc = cnt_p < CAP_P;
				if (acc) begin
					cmd.mode = CELL_WRITE;
					cmd.pos  = cnt_p;
					next_cnt = cnt_p + 1'b1;
				end
			end
			ACT_POP: begin
				acc = cnt_p != '0;
				if (acc)
					next_cnt = cnt_p - 1'b1;
			end
			ACT_CLEAR: begin
				acc      = 1'b1;
				next_cnt = '0;
			end
			ACT_GET: acc = idx_p < cnt_p;
			ACT_CONTAINS: acc = 1'b1;
			default: acc = 1'b0;
		endcase
		// only touch the cells on an accepted transaction
		if (!in_fire)
			cmd.mode = CELL_HOLD;
		cmd.top_pos = next_cnt - 1'b1;
	end

	for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
		logic [SYM_W-1:0] left_in;
		logic [SYM_W-1:0] right_in;
		if (k == 0) begin : g_first
			assign left_in = '0;
		end else begin : g_mid_l
			assign left_in = cell_q[k-1];
		end
		if (k == CAPACITY - 1) begin : g_last
			assign right_in = cell_q[k];
		end else begin : g_mid_r
			assign right_in = cell_q[k+1];
		end
		blsl_cell #(
			.POS(k)
		) u_cell (
			.clk  (clk),
			.cmd  (cmd),
			.left (left_in),
			.right(right_in),
			.q    (cell_q[k]),
			.rsp  (rsp[k])
		);
	end

	always_comb begin
		rd_or  = '0;
		tp_or  = '0;
		fnd_or = 1'b0;
		for (int k = 0; k < CAPACITY; k++) begin
			rd_or  = rd_or | rsp[k].rd;
			tp_or  = tp_or | rsp[k].tp;
			fnd_or = fnd_or | rsp[k].fnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				count_q     <= CW'(next_cnt);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (act == ACT_GET)
				read_value_q <= acc ? OUT_W'(rd_or) : SENTINEL;
			else
				read_value_q <= '0;
			found_q      <= (act == ACT_CONTAINS) && fnd_or;
			top_value_q  <= (next_cnt == '0) ? SENTINEL : OUT_W'(tp_or);
			length_q     <= LEN_W'(next_cnt);
			accepted_q   <= acc;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign found      = found_q;
	assign top_value  = top_value_q;
	assign length     = length_q;
	assign accepted   = accepted_q;

endmodule

// ===== hdl/blsl_cell.sv =====
// one list slot: holds an entry and trades it with its neighbors on shifts
module blsl_cell #(
	parameter int POS = 0
) (
	input  logic                   clk,
	input  blsl_pkg::cell_cmd_t    cmd,
	input  logic [blsl_pkg::SYM_W-1:0] left,
	input  logic [blsl_pkg::SYM_W-1:0] right,
	output logic [blsl_pkg::SYM_W-1:0] q,
	output blsl_pkg::cell_rsp_t    rsp
);
	import blsl_pkg::*;

	localparam logic [POS_W-1:0] MY_POS = POS_W'(POS);

	logic [SYM_W-1:0] entry_q;
	logic [SYM_W-1:0] d;

	always_comb begin
		d = entry_q;
		unique case (cmd.mode)
			CELL_SHIFT_UP: begin
				if (MY_POS == cmd.pos)
					d = cmd.sym;
				else if (MY_POS > cmd.pos)
					d = left;
			end
			CELL_SHIFT_DOWN: begin
				if (MY_POS >= cmd.pos)
					d = right;
			end
			CELL_WRITE: begin
				if (MY_POS == cmd.pos)
					d = cmd.sym;
			end
			default: d = entry_q;
		endcase
	end

	always_ff @(posedge clk) begin
		entry_q <= d;
	end

	assign q       = entry_q;
	assign rsp.rd  = (MY_POS == cmd.pos) ? entry_q : '0;
	assign rsp.fnd = (entry_q == cmd.sym) && (MY_POS < cmd.cnt);
	// top after the operation comes from the next value
	assign rsp.tp  = (MY_POS == cmd.top_pos) ? d : '0;

endmodule
